// File: src/bbd_pkg.sv
package bbd_pkg;

  // Widths fixed by the pixel and register formats.
  localparam int PIX_W         = 8;
  localparam int PHASE_W       = 2;
  localparam int LINE_WIDTH_W  = 12;
  localparam int CFG_DATA_W    = 12;
  localparam int ROW_W         = 16;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MIN_WIDTH     = 3;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd64;
  localparam logic [PHASE_W-1:0]      PHASE_RST      = 2'd0;
  localparam logic [ROW_W-1:0]        ROW_TOP        = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BAYER_PHASE = 1'b0,
    REG_LINE_WIDTH  = 1'b1
  } cfg_idx_t;

  // Colour selection for the window centre, row match in the upper bit.
  typedef enum logic [1:0] {
    SITE_RED   = 2'b11,
    SITE_GR    = 2'b10,
    SITE_GB    = 2'b01,
    SITE_BLUE  = 2'b00
  } site_t;

  // Truncated mean of four samples.
  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[PIX_W+1:2];
  endfunction

  // Truncated mean of two samples.
  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    logic [PIX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PIX_W:1];
  endfunction

endpackage

// File: src/bayer_bilinear_demosaic.sv
// Bilinear Bayer demosaic over a 3x3 window. Raw 8-bit samples arrive in raster
// order on the slave stream, one request per clock, and the block takes one every
// cycle whenever its output register is free or being emptied. Each pixel costs one
// read and one write on each of two line memories (MAX_WIDTH entries of 8 bits,
// registered read); the read is issued when the request is accepted and the
// write-back happens when the request leaves stage one, with forwarding when two
// successive requests hit the same column. A result passes from stage one into the
// output register. Once two full rows and two columns have been seen, every
// pixel yields one RGB result for the window centre, so an output row holds
// line_width-2 pixels and tlast marks its last one; no border padding is done.
// bayer_phase selects the red site (bit 0 column parity, bit 1 row parity) and
// line_width sets the raw row length, clamped to 3..MAX_WIDTH. tuser on the input
// marks the first pixel of a frame and restarts the position counters. The line
// memories are not cleared after reset: the first two rows of a frame fill them
// before any of their contents reach an output. Configuration must only be written
// while no request is in flight.
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [PIX_W-1:0]        s_axis_tdata,   // [7:0] raw_pixel
  input  logic                    s_axis_tuser,   // [0] frame_start
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [3*PIX_W-1:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                    m_axis_tlast    // row_end
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int MWW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (MWW > LINE_WIDTH_W) ? MWW : LINE_WIDTH_W;

  localparam logic [EW-1:0] EW_MIN = EW'(MIN_WIDTH);
  localparam logic [EW-1:0] EW_MAX = EW'(MAX_WIDTH);

  // Configuration registers.
  logic [PHASE_W-1:0]      bayer_phase;
  logic [LINE_WIDTH_W-1:0] line_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      bayer_phase <= PHASE_RST;
      line_width  <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BAYER_PHASE: bayer_phase <= cfg_data[PHASE_W-1:0];
        REG_LINE_WIDTH:  line_width  <= cfg_data[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row length minus one, used as the last column index.
  logic [EW-1:0] width_ext;
  logic [EW-1:0] width_eff;
  logic [EW-1:0] last_col;

  always_comb begin
    width_ext = EW'(line_width);
    if (width_ext < EW_MIN) begin
      width_eff = EW_MIN;
    end else if (width_ext > EW_MAX) begin
      width_eff = EW_MAX;
    end else begin
      width_eff = width_ext;
    end
    last_col = width_eff - EW'(1);
  end

  // Accept stage: position counters and the line memory read request.
  logic [AW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;
  logic [AW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             at_row_end;
  logic             accept;

  // Stage one: read data returns, window shifts, memories are written back.
  logic             s1_valid;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_emit;
  logic             s1_rowm;
  logic             s1_colm;
  logic             s1_last;
  logic             s1_fwd;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;
  logic             s1_stall;
  logic             s1_adv;

  always_comb begin
    col_cur    = s_axis_tuser ? '0 : column_count;
    row_cur    = s_axis_tuser ? '0 : row_count;
    at_row_end = EW'(col_cur) >= last_col;
  end

  // Stage one only stalls when it holds a result and the output register is full
  // and not being drained; the next request waits for it.
  assign s1_stall      = s1_valid && s1_emit && m_axis_tvalid && !m_axis_tready;
  assign s1_adv        = s1_valid && !s1_stall;
  assign s_axis_tready = !s1_stall;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (at_row_end) begin
        column_count <= '0;
        row_count    <= (row_cur == ROW_TOP) ? ROW_TOP - ROW_W'(1) : row_cur + ROW_W'(1);
      end else begin
        column_count <= col_cur + AW'(1);
        row_count    <= row_cur;
      end
    end
  end

  // Line memories: the upper row and the middle row of the window.
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;
  logic [PIX_W-1:0] top_eff;
  logic [PIX_W-1:0] mid_eff;

  // The previous request's write lands in the same cycle as this read; a repeated
  // column takes the written values from the forwarding registers instead.
  assign top_eff = s1_fwd ? fwd_top : top_rd;
  assign mid_eff = s1_fwd ? fwd_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      top_mem[s1_addr] <= mid_eff;
    end
    if (accept) begin
      top_rd <= top_mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mid_mem[s1_addr] <= s1_pix;
    end
    if (accept) begin
      mid_rd <= mid_mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_fwd   <= s1_adv && (s1_addr == col_cur);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= col_cur;
      s1_pix  <= s_axis_tdata;
      s1_emit <= (row_cur >= ROW_W'(2)) && (col_cur >= AW'(2));
      s1_rowm <= row_cur[0] == bayer_phase[1];
      s1_colm <= col_cur[0] == bayer_phase[0];
      s1_last <= at_row_end;
      fwd_top <= mid_eff;
      fwd_mid <= s1_pix;
    end
  end

  // 3x3 window, index row*3 + column with row 0 at the top.
  logic [PIX_W-1:0] win      [9];
  logic [PIX_W-1:0] win_next [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = top_eff;
    win_next[5] = mid_eff;
    win_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // Interpolation of the missing colours from the shifted window.
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] nesw;
  logic [PIX_W-1:0] diag;
  logic [PIX_W-1:0] vert;
  logic [PIX_W-1:0] horiz;
  logic [PIX_W-1:0] red_next;
  logic [PIX_W-1:0] green_next;
  logic [PIX_W-1:0] blue_next;
  site_t            site;

  always_comb begin
    centre = win_next[4];
    nesw   = avg4(win_next[3], win_next[5], win_next[1], win_next[7]);
    diag   = avg4(win_next[0], win_next[2], win_next[6], win_next[8]);
    vert   = avg2(win_next[1], win_next[7]);
    horiz  = avg2(win_next[3], win_next[5]);
    site   = site_t'({s1_rowm, s1_colm});
    case (site)
      SITE_RED: begin
        red_next = centre; green_next = nesw;   blue_next = diag;
      end
      SITE_GR: begin
        red_next = horiz;  green_next = centre; blue_next = vert;
      end
      SITE_GB: begin
        red_next = vert;   green_next = centre; blue_next = horiz;
      end
      default: begin
        red_next = diag;   green_next = nesw;   blue_next = centre;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_axis_tdata <= {blue_next, green_next, red_next};
      m_axis_tlast <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // At its all-ones value the row counter steps back by one instead of wrapping.
  a_row_ceiling: assert property (@(posedge clk) disable iff (rst)
    (accept && at_row_end && (row_cur == ROW_TOP)) |=> (row_count == ROW_TOP - ROW_W'(1)))
    else $error("row counter wrapped past its all-ones value");

  // After a request the column counter never passes the last column.
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    accept |=> EW'(column_count) <= last_col)
    else $error("column counter beyond the row end");

  // Forwarding is only armed for a request that sits in stage one.
  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("forwarding armed without a request in stage one");

  // A result leaving stage one always reaches the output register.
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_emit) |=> m_axis_tvalid)
    else $error("result from stage one lost");
`endif

endmodule

// File: tb/sv/tb_bayer_bilinear_demosaic.sv
`timescale 1ns / 100ps

// Self-checking bench for the Bayer demosaic block.
//
// Raw pixels are offered as requests on the slave stream. Each accepted
// request is also run through a behavioural copy of the block held here: two
// line memories, the 3x3 window and the column and row counters. When that
// copy produces an RGB pixel, the pixel is queued. Every result taken from the
// master stream is compared field by field with the oldest queued pixel.
//
// The tests cover the reset defaults, all four colour sites under every phase,
// widths below the legal range, a width lowered in the middle of a row and
// heavy output back pressure. The run ends with randomised frames under four
// idling mixes.
module tb_bayer_bilinear_demosaic;
  import bbd_pkg::*;

  localparam int MAX_W     = MAX_WIDTH_DEF;
  localparam int RUN_LIMIT = 1_000_000;

  // Pixel patterns used to build frames.
  typedef enum int {
    PAT_RANDOM,
    PAT_WHITE,
    PAT_BLACK,
    PAT_CHECKER
  } pat_t;

  // One reconstructed pixel as it leaves the block.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
  } rgb_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;   // [7:0] raw_pixel
  logic                  s_axis_tuser;   // [0] frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [3*PIX_W-1:0]    m_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic                  m_axis_tlast;   // row_end

  // Idling mix, in percent of cycles, and the long receiver hold-off.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int rx_hold_ask    = 0;
  int rx_hold_left   = 0;
  int mismatches     = 0;

  // Behavioural copy of the block's state and configuration.
  logic [PIX_W-1:0]        line_mem [0:2*MAX_W-1] = '{default: '0};
  logic [PIX_W-1:0]        win      [0:8]         = '{default: '0};
  logic [10:0]             col_cnt   = '0;
  logic [ROW_W-1:0]        row_cnt   = '0;
  logic [PHASE_W-1:0]      phase_q   = PHASE_RST;
  logic [LINE_WIDTH_W-1:0] width_q   = LINE_WIDTH_RST;

  // Pixels the block still owes us, oldest first.
  rgb_t rgb_expected[$];

  bayer_bilinear_demosaic dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Steps the behavioural copy by one accepted raw pixel. The window is shifted
  // first and the colours are then worked out from the shifted window, exactly
  // as the hardware sees it. The centre sits one row and one column behind the
  // incoming pixel, so no pixel is produced until two rows and two columns
  // have gone by.
  function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic fs);
    logic [LINE_WIDTH_W-1:0] w;
    logic [PIX_W-1:0]        top, mid, cen, nesw, diag, vert, horiz;
    logic [PIX_W+1:0]        sum4;
    logic [PIX_W:0]          sum2;
    logic                    row_match, col_match;
    site_t                   site;
    rgb_t                    res;
    // Widths outside the legal range are clamped, not rejected.
    if (width_q < MIN_WIDTH)
      w = LINE_WIDTH_W'(MIN_WIDTH);
    else if (width_q > MAX_W)
      w = LINE_WIDTH_W'(MAX_W);
    else
      w = width_q;
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    top = line_mem[col_cnt];
    mid = line_mem[MAX_W + col_cnt];
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    // The upper memory takes what the lower one held: a two-line delay.
    line_mem[col_cnt]         = mid;
    line_mem[MAX_W + col_cnt] = pix;
    if (row_cnt >= 2 && col_cnt >= 2) begin
      cen   = win[4];
      sum4  = (PIX_W+2)'(win[1]) + (PIX_W+2)'(win[3]) + (PIX_W+2)'(win[5]) + (PIX_W+2)'(win[7]);
      nesw  = sum4[PIX_W+1:2];
      sum4  = (PIX_W+2)'(win[0]) + (PIX_W+2)'(win[2]) + (PIX_W+2)'(win[6]) + (PIX_W+2)'(win[8]);
      diag  = sum4[PIX_W+1:2];
      sum2  = (PIX_W+1)'(win[1]) + (PIX_W+1)'(win[7]);
      vert  = sum2[PIX_W:1];
      sum2  = (PIX_W+1)'(win[3]) + (PIX_W+1)'(win[5]);
      horiz = sum2[PIX_W:1];
      row_match = (row_cnt[0] == phase_q[1]);
      col_match = (col_cnt[0] == phase_q[0]);
      site = site_t'({row_match, col_match});
      case (site)
        SITE_RED: begin
          res.red = cen;   res.green = nesw; res.blue = diag;
        end
        SITE_GR: begin
          res.red = horiz; res.green = cen;  res.blue = vert;
        end
        SITE_GB: begin
          res.red = vert;  res.green = cen;  res.blue = horiz;
        end
        default: begin
          res.red = diag;  res.green = nesw; res.blue = cen;
        end
      endcase
      res.row_end = (col_cnt >= w - 1);
      rgb_expected.push_back(res);
    end
    // A column at or past the last one ends the row, which also covers a width
    // lowered while a row was under way. The row counter saturates by toggling
    // between its two top values so that parity keeps alternating.
    if (col_cnt >= w - 1) begin
      col_cnt = '0;
      row_cnt = (row_cnt == ROW_TOP) ? ROW_TOP - ROW_W'(1) : row_cnt + ROW_W'(1);
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    // Lean on the extremes now and then so that the sums reach their extremes.
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [PIX_W-1:0] pattern_pixel(pat_t pat, int r, int c);
    case (pat)
      PAT_WHITE:   return 8'hFF;
      PAT_BLACK:   return 8'h00;
      PAT_CHECKER: return ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
      default:     return rand_pixel();
    endcase
  endfunction

  // Offers one raw pixel and returns at the falling edge after the request has
  // been accepted. tvalid is left high so that back-to-back requests need no
  // second assignment in the same time step; any caller that stops sending
  // lowers it itself.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pixel(pix, fs);
    @(negedge clk);
  endtask

  task automatic send_rows(input int w, input int rows, input pat_t pat, input logic first_start);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < w; c++)
        send_pixel(pattern_pixel(pat, r, c), first_start && r == 0 && c == 0);
  endtask

  // Stops sending and waits until every owed pixel has come out, then idles on,
  // since the last pixels of a row may still be in the pipeline without
  // producing anything.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_BAYER_PHASE: phase_q = value[PHASE_W-1:0];
      default:         width_q = value[LINE_WIDTH_W-1:0];
    endcase
  endtask

  // Only the low bits of a phase write matter; the rest are filled at random.
  task automatic write_phase(input logic [PHASE_W-1:0] ph);
    write_reg(REG_BAYER_PHASE, {(CFG_DATA_W-PHASE_W)'($urandom()), ph});
  endtask

  // Reset values: width 64 and phase 0, with the first frame sent without a
  // frame start so that the counters simply run on from zero.
  task automatic test_reset_defaults();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_rows(64, 3, PAT_RANDOM, 1'b0);
  endtask

  // A width of four gives output columns of both parities on two output rows,
  // so each phase visits all four colour sites. The patterns push the averages
  // to their extremes.
  task automatic test_colour_sites();
    send_gap_pct   = 26;
    recv_stall_pct = 26;
    wait_results_done();
    write_reg(REG_LINE_WIDTH, 12'd4);
    for (int ph = 0; ph < 4; ph++) begin
      wait_results_done();
      write_phase(PHASE_W'(ph));
      case (ph)
        0:       send_rows(4, 4, PAT_WHITE, 1'b1);
        1:       send_rows(4, 4, PAT_CHECKER, 1'b1);
        2:       send_rows(4, 4, PAT_BLACK, 1'b1);
        default: send_rows(4, 4, PAT_RANDOM, 1'b1);
      endcase
    end
  endtask

  // Widths below three behave as three.
  task automatic test_narrow_widths();
    send_gap_pct   = 46;
    recv_stall_pct = 0;
    for (int wv = 0; wv < MIN_WIDTH; wv++) begin
      wait_results_done();
      write_reg(REG_LINE_WIDTH, CFG_DATA_W'(wv));
      write_phase(PHASE_W'($urandom_range(3)));
      send_rows(MIN_WIDTH, 4, PAT_RANDOM, 1'b1);
    end
  endtask

  // The width is lowered while a row is half done. The column counter is then
  // already past the new last column, so the next pixel ends the row and
  // carries row_end.
  task automatic test_width_cut_mid_row();
    send_gap_pct   = 0;
    recv_stall_pct = 46;
    wait_results_done();
    write_reg(REG_LINE_WIDTH, 12'd10);
    write_phase(2'd1);
    send_rows(10, 2, PAT_RANDOM, 1'b1);
    for (int c = 0; c < 7; c++)
      send_pixel(rand_pixel(), 1'b0);
    wait_results_done();
    write_reg(REG_LINE_WIDTH, 12'd5);
    for (int n = 0; n < 11; n++)
      send_pixel(rand_pixel(), 1'b0);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills and stops accepting. Part way through the frame the sender
  // pauses until every owed pixel has arrived, then carries on.
  task automatic test_output_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    wait_results_done();
    write_reg(REG_LINE_WIDTH, 12'd8);
    write_phase(2'd3);
    @(posedge clk);
    rx_hold_ask = 300;
    @(negedge clk);
    send_rows(8, 4, PAT_RANDOM, 1'b1);
    wait_results_done();
    send_rows(8, 2, PAT_RANDOM, 1'b0);
  endtask

  // Random frames, mostly well formed with random content. Some are cut
  // short, some are too short to yield anything, and now and then a frame
  // start lands in the middle of a row.
  task automatic test_random_frames(input int gap, input int stall, input int budget);
    int                    sent, w, rows, cut;
    logic [CFG_DATA_W-1:0] wreg;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < budget) begin
      wait_results_done();
      case ($urandom_range(7))
        0:       wreg = CFG_DATA_W'($urandom_range(MIN_WIDTH - 1));
        1:       wreg = CFG_DATA_W'($urandom_range(40, 13));
        default: wreg = CFG_DATA_W'($urandom_range(10, MIN_WIDTH));
      endcase
      write_reg(REG_LINE_WIDTH, wreg);
      write_phase(PHASE_W'($urandom_range(3)));
      w    = (wreg < MIN_WIDTH) ? MIN_WIDTH : int'(wreg);
      rows = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(5, 3);
      cut  = w * rows;
      if ($urandom_range(5) == 0)
        cut = $urandom_range(cut, 1);
      for (int n = 0; n < cut; n++)
        send_pixel(rand_pixel(), n == 0 || $urandom_range(49) == 0);
      sent += cut;
    end
  endtask

  // Receiver side: random stalls, or a counted hold-off when one is asked for.
  always @(negedge clk) begin
    if (rx_hold_ask > 0) begin
      rx_hold_left = rx_hold_ask;
      rx_hold_ask  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Every accepted result is held against the oldest owed pixel.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        $display("%0t: no pixel expected, got rgb %h last %b", $time,
                 m_axis_tdata, m_axis_tlast);
      end else begin
        want = rgb_expected.pop_front();
        check_field("red", want.red, m_axis_tdata[PIX_W-1:0]);
        check_field("green", want.green, m_axis_tdata[2*PIX_W-1:PIX_W]);
        check_field("blue", want.blue, m_axis_tdata[3*PIX_W-1:2*PIX_W]);
        check_field("row_end", want.row_end, m_axis_tlast);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int waited;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = REG_BAYER_PHASE;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_colour_sites();
    test_narrow_widths();
    test_width_cut_mid_row();
    test_output_backpressure();
    test_random_frames(0, 0, 10);
    test_random_frames(46, 0, 10);
    test_random_frames(0, 46, 10);
    test_random_frames(26, 26, 10);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (rgb_expected.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (rgb_expected.size() != 0)
        $display("%0t: %0d expected pixels never arrived", $time, rgb_expected.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/bbd_pkg.sv
src/bayer_bilinear_demosaic.sv
tb/sv/tb_bayer_bilinear_demosaic.sv
